/* src/pftm_pkg.sv */
//------------------------------------------------------------------------------
// pftm_pkg
// Shared types and constants for the particle frame trimmed-mean core.
//------------------------------------------------------------------------------
package pftm_pkg;

	localparam int MaxFrames = 4096;
	localparam int CntW      = 13;
	localparam int SumW      = 29;
	localparam int NumCh     = 6;
	localparam int QuoW      = 37;
	localparam int DivSteps  = 37;

	localparam logic [7:0] Hdr1 = 8'h81;
	localparam logic [7:0] Hdr2 = 8'h11;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_HDR2,
		PH_STATUS,
		PH_BODY,
		PH_CSUM
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LOAD,
		ST_DIV,
		ST_EMIT,
		ST_ERR
	} state_t;

	typedef struct packed {
		logic take_byte;
		logic clear_acc;
		logic div_load;
		logic div_step;
		logic next_ch;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic div_done;
		logic last_ch;
	} stat_t;

	// map from data word position in a frame to channel
	function automatic logic [2:0] word_channel(input logic [2:0] k);
		logic [2:0] c;
		case (k)
			3'd0: c = 3'd3;
			3'd1: c = 3'd5;
			3'd2: c = 3'd4;
			3'd3: c = 3'd0;
			3'd4: c = 3'd2;
			3'd5: c = 3'd1;
			default: c = 3'd0;
		endcase
		return c;
	endfunction

endpackage

/* src/particle_frame_trimmed_mean_core.sv */
//------------------------------------------------------------------------------
// particle_frame_trimmed_mean_core
// Sensor frame parser with per-channel trimmed-mean reporting.
//------------------------------------------------------------------------------
// Input channel (in_valid/in_stall): opcode 0 carries a received byte, taken
// in the same cycle while the core is idle; opcode 1 asks for the six channel means and clears the
// accumulators. Output channel (out_valid/out_stall): one transaction per
// channel 0..5, last set on channel 5, or a single error transaction with
// status 1 when no frames were collected.
// A collect passes a check state, then per channel a load state, a
// divider state that runs the 37 steps of the bit-serial divider and
// sees it done, and an emit state that holds while the result is
// stalled. An error result is emitted straight after the check state.
// Input is stalled during a collect; a stalled result is held unchanged
// and the sequence waits. Reset clears the parser to header hunting and
// empties the sums, minimums (all ones) and maximums.
//------------------------------------------------------------------------------
module particle_frame_trimmed_mean_core import pftm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  channel,
	output logic [23:0] mean_value,
	output logic [12:0] frames_used,
	output logic        status,
	output logic        last
);

	cmd_t  cmd;
	stat_t stat;
	logic  err;
	logic [2:0]  ch_i;
	logic [23:0] mean_i;
	logic [12:0] used_i;

	pftm_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .opcode, .out_valid, .out_stall,
		.stat, .cmd, .err
	);

	pftm_datapath u_dp (
		.clk, .arst_n, .cmd, .rx_byte, .stat, .channel(ch_i),
		.mean_value(mean_i), .frames_used(used_i)
	);

	assign channel     = err ? 3'd0 : ch_i;
	assign mean_value  = err ? 24'd0 : mean_i;
	assign frames_used = err ? 13'd0 : used_i;
	assign status      = err;
	assign last        = err | stat.last_ch;

endmodule

/* src/pftm_datapath.sv */
//------------------------------------------------------------------------------
// pftm_datapath
// Frame parser, accumulators and a restoring serial divider for the means.
//------------------------------------------------------------------------------
module pftm_datapath import pftm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic [7:0]  rx_byte,
	output stat_t       stat,
	output logic [2:0]  channel,
	output logic [23:0] mean_value,
	output logic [12:0] frames_used
);

	phase_t      phase_q;
	logic [3:0]  idx_q;
	logic [7:0]  csum_q;
	logic [7:0]  fb_q [12];
	logic [27:0] sum_q [NumCh];
	logic [15:0] min_q [NumCh];
	logic [15:0] max_q [NumCh];
	logic [12:0] cnt_q;
	logic [2:0]  ch_q;
	logic [QuoW-1:0] rem_q, quo_q;
	logic [SumW+7:0] num_q;
	logic [5:0]  step_q;
	logic [7:0]  csum_n;
	logic        trim;
	logic [12:0] used;

	assign csum_n = csum_q + rx_byte;
	assign trim   = cnt_q > 13'd2;
	assign used   = trim ? cnt_q - 13'd2 : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			idx_q   <= '0;
			csum_q  <= '0;
		end else if (cmd.take_byte) begin
			case (phase_q)
				PH_HUNT: if (rx_byte == Hdr1) phase_q <= PH_HDR2;
				PH_HDR2: begin
					if (rx_byte == Hdr2) begin
						phase_q <= PH_STATUS;
						csum_q  <= Hdr1 + Hdr2;
					end else if (rx_byte != Hdr1) begin
						phase_q <= PH_HUNT;
					end
				end
				PH_STATUS: begin
					csum_q  <= csum_n;
					idx_q   <= '0;
					phase_q <= PH_BODY;
				end
				PH_BODY: begin
					csum_q <= csum_n;
					if (idx_q == 4'd11) begin
						idx_q   <= '0;
						phase_q <= PH_CSUM;
					end else begin
						idx_q <= idx_q + 4'd1;
					end
				end
				PH_CSUM: begin
					csum_q  <= '0;
					phase_q <= PH_HUNT;
				end
				default: phase_q <= PH_HUNT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_byte && phase_q == PH_BODY && idx_q < 4'd12)
			fb_q[idx_q] <= rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int c = 0; c < NumCh; c++) begin
				sum_q[c] <= '0;
				min_q[c] <= 16'hFFFF;
				max_q[c] <= '0;
			end
		end else if (cmd.clear_acc) begin
			cnt_q <= '0;
			for (int c = 0; c < NumCh; c++) begin
				sum_q[c] <= '0;
				min_q[c] <= 16'hFFFF;
				max_q[c] <= '0;
			end
		end else if (cmd.take_byte && phase_q == PH_CSUM && csum_n == 8'd0
				&& {19'd0, cnt_q} < MaxFrames) begin
			cnt_q <= cnt_q + 13'd1;
			for (int k = 0; k < NumCh; k++) begin
				logic [15:0] v;
				logic [2:0]  c;
				v = {fb_q[2*k], fb_q[2*k+1]};
				c = word_channel(3'(k));
				sum_q[c] <= sum_q[c] + {12'd0, v};
				if (v < min_q[c]) min_q[c] <= v;
				if (v > max_q[c]) max_q[c] <= v;
			end
		end
	end

	// serial restoring divide of (sum << 8), trimmed of min and max when more than two frames, by the frames used
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q   <= '0;
			step_q <= '0;
			num_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (cmd.div_load) begin
			logic [28:0] s, t;
			s = {1'b0, sum_q[ch_q]};
			t = {13'd0, min_q[ch_q]} + {13'd0, max_q[ch_q]};
			if (trim) s = (s >= t) ? s - t : '0;
			num_q  <= {s, 8'd0};
			rem_q  <= '0;
			quo_q  <= '0;
			step_q <= '0;
		end else if (cmd.div_step) begin
			logic [QuoW:0] r;
			r = {rem_q, num_q[SumW+7]};
			num_q <= {num_q[SumW+6:0], 1'b0};
			if (r >= {25'd0, used}) begin
				rem_q <= QuoW'(r - {25'd0, used});
				quo_q <= {quo_q[QuoW-2:0], 1'b1};
			end else begin
				rem_q <= QuoW'(r);
				quo_q <= {quo_q[QuoW-2:0], 1'b0};
			end
			step_q <= step_q + 6'd1;
		end else if (cmd.clear_acc) begin
			ch_q <= '0;
		end else if (cmd.next_ch) begin
			ch_q <= ch_q + 3'd1;
		end
	end

	assign stat.empty    = used == 13'd0;
	assign stat.div_done = step_q == 6'(DivSteps);
	assign stat.last_ch  = ch_q == 3'd5;

	assign channel     = ch_q;
	assign mean_value  = (quo_q[QuoW-1:24] != '0) ? 24'hFFFFFF : quo_q[23:0];
	assign frames_used = used;

endmodule

/* src/pftm_ctrl.sv */
//------------------------------------------------------------------------------
// pftm_ctrl
// Sequencer for byte intake, the six divisions and the result handshake.
//------------------------------------------------------------------------------
module pftm_ctrl import pftm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  logic  opcode,
	output logic  out_valid,
	input  logic  out_stall,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  err
);

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_n;
	end

	always_comb begin
		state_n   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		err       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (opcode) state_n = ST_CHECK;
					else        cmd.take_byte = 1'b1;
				end
			end
			ST_CHECK: state_n = stat.empty ? ST_ERR : ST_LOAD;
			ST_LOAD: begin
				cmd.div_load = 1'b1;
				state_n = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_done) state_n = ST_EMIT;
				else               cmd.div_step = 1'b1;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (stat.last_ch) begin
						cmd.clear_acc = 1'b1;
						state_n = ST_IDLE;
					end else begin
						cmd.next_ch = 1'b1;
						state_n = ST_LOAD;
					end
				end
			end
			ST_ERR: begin
				out_valid = 1'b1;
				err = 1'b1;
				if (!out_stall) begin
					cmd.clear_acc = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

endmodule
